// ===== design/bpts_pkg.sv =====
// Shared types and constants for the bitmap priority task scheduler.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package bpts_pkg;

  localparam int NUM_TASKS = 32;
  localparam int TASK_W    = 5;   // task number width, fixed by the result fields
  localparam int IDX_W     = 6;   // sweep index, must hold NUM_TASKS itself
  localparam int DATA_W    = 32;

  localparam logic [DATA_W-1:0] TASK_MASK = 32'hFFFF_FFFF >> (DATA_W - NUM_TASKS);
  localparam logic [IDX_W-1:0]  IDX_TASKS = IDX_W'(NUM_TASKS);
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(NUM_TASKS - 1);

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_READY    = 3'd1,
    CMD_BLOCK    = 3'd2,
    CMD_DELAY    = 3'd3,
    CMD_SCHEDULE = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [DATA_W-1:0] ready_mask;
    logic [DATA_W-1:0] delay_ticks;
  } in_req_t;

  typedef struct packed {
    logic [TASK_W-1:0] chosen_task;
    logic              none_ready;
    logic [DATA_W-1:0] ready_now;
    logic [TASK_W-1:0] running_task;
  } out_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic sweep;
    logic search;
    logic finish;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic search_done;
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== design/bpts_ctrl.sv =====
// Controller state machine of the task scheduler.
// Depends on bpts_pkg; drives the datapath through ctl_cmd_t.
`timescale 1ns / 1ps

module bpts_ctrl import bpts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_cmd,
  output logic       in_stall,
  input  dp_stat_t   stat,
  output ctl_cmd_t   ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_TICK) begin
            state_nxt = ST_SWEEP;
          end else if (in_cmd == CMD_SCHEDULE) begin
            state_nxt = ST_SEARCH;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_EXEC:   state_nxt = ST_FINISH;
      ST_SWEEP:  if (stat.sweep_last) state_nxt = ST_FINISH;
      ST_SEARCH: if (stat.search_done) state_nxt = ST_FINISH;
      ST_FINISH: if (!stat.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        ctl.accept = in_valid;
      end
      ST_EXEC:   ctl.exec   = 1'b1;
      ST_SWEEP:  ctl.sweep  = 1'b1;
      ST_SEARCH: ctl.search = 1'b1;
      ST_FINISH: ctl.finish = !stat.out_busy;
      default:   in_stall   = 1'b1;
    endcase
  end

endmodule

// ===== design/bpts_dp.sv =====
// Datapath of the task scheduler: ready mask, current task, delay counter
// memory with valid bits, sweep/search index and the result register. Uses bpts_pkg.
`timescale 1ns / 1ps

module bpts_dp import bpts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  in_req_t  in_data,
  input  ctl_cmd_t ctl,
  output dp_stat_t stat,
  input  logic     out_stall,
  output logic     out_valid,
  output out_rsp_t out_data
);

  logic [DATA_W-1:0]    ready_r;
  logic [TASK_W-1:0]    cur_r;
  logic [IDX_W-1:0]     idx_r;
  logic [NUM_TASKS-1:0] vld_r;
  logic                 out_valid_r;

  logic [2:0]           cmd_r;
  logic [DATA_W-1:0]    mask_r;
  logic [DATA_W-1:0]    ticks_r;
  logic [TASK_W-1:0]    chosen_r;
  logic                 none_r;
  out_rsp_t             out_data_r;

  logic [DATA_W-1:0]    cnt_mem [NUM_TASKS];
  logic [DATA_W-1:0]    rdata_r;
  logic                 rvld_r;

  logic [TASK_W-1:0]    rd_addr;
  logic [IDX_W-1:0]     prev_idx;
  logic [TASK_W-1:0]    prev_addr;
  logic                 cur_ok;
  logic                 dec_en;
  logic                 wake;
  logic                 delay_wr;
  logic                 wr_en;
  logic [TASK_W-1:0]    wr_addr;
  logic [DATA_W-1:0]    wr_data;
  logic                 search_hit;
  logic [DATA_W-1:0]    clr_bit;

  assign rd_addr   = idx_r[TASK_W-1:0];
  assign prev_idx  = idx_r - 1'b1;
  assign prev_addr = prev_idx[TASK_W-1:0];
  assign cur_ok    = {1'b0, cur_r} < IDX_TASKS;
  assign clr_bit   = DATA_W'(1) << cur_r;

  // entry idx-1 comes back from memory while entry idx is being read
  assign dec_en   = ctl.sweep && (idx_r != '0) && rvld_r && (rdata_r != '0);
  assign wake     = dec_en && (rdata_r == DATA_W'(1));
  assign delay_wr = ctl.exec && (cmd_r == CMD_DELAY) && cur_ok;

  always_comb begin
    wr_en   = dec_en || delay_wr;
    wr_addr = prev_addr;
    wr_data = rdata_r - 1'b1;
    if (delay_wr) begin
      wr_addr = cur_r;
      wr_data = ticks_r;
    end
  end

  assign search_hit       = ready_r[idx_r[TASK_W-1:0]];
  assign stat.sweep_last  = (idx_r == IDX_TASKS);
  assign stat.search_done = search_hit || (idx_r == IDX_LAST);
  assign stat.out_busy    = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem[wr_addr] <= wr_data;
    end
    rdata_r <= cnt_mem[rd_addr];
    rvld_r  <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r     <= '0;
      cur_r       <= '0;
      idx_r       <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.accept) begin
        idx_r <= '0;
      end
      if (delay_wr) begin
        vld_r[cur_r] <= 1'b1;
      end
      if (ctl.exec) begin
        if (cmd_r == CMD_READY) begin
          ready_r <= ready_r | (mask_r & TASK_MASK);
        end else if ((cmd_r == CMD_BLOCK || cmd_r == CMD_DELAY) && cur_ok) begin
          ready_r <= ready_r & ~clr_bit;
        end
      end
      if (ctl.sweep) begin
        idx_r <= idx_r + 1'b1;
        if (wake) begin
          ready_r[prev_addr] <= 1'b1;
        end
      end
      if (ctl.search) begin
        if (search_hit) begin
          cur_r <= idx_r[TASK_W-1:0];
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
      // drop the taken result, then load the new one
      if (ctl.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r    <= in_data.cmd;
      mask_r   <= in_data.ready_mask;
      ticks_r  <= in_data.delay_ticks;
      chosen_r <= '0;
      none_r   <= 1'b0;
    end
    if (ctl.search) begin
      if (search_hit) begin
        chosen_r <= idx_r[TASK_W-1:0];
      end else if (idx_r == IDX_LAST) begin
        none_r <= 1'b1;
      end
    end
    if (ctl.finish) begin
      out_data_r.chosen_task  <= chosen_r;
      out_data_r.none_ready   <= none_r;
      out_data_r.ready_now    <= ready_r & TASK_MASK;
      out_data_r.running_task <= cur_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/bitmap_priority_task_scheduler.sv =====
// Top level of the bitmap priority task scheduler.
// Instantiates bpts_ctrl and bpts_dp; types come from bpts_pkg.
`timescale 1ns / 1ps

// Takes one request at a time and returns one result per request. Ready,
// block, delay and unused command codes pass through the exec and finish
// states. A tick sweeps the delay counters, which live in a memory with one
// read and one write port, one entry per cycle, read and written back in an
// overlapped two-step pipeline. A schedule scans the ready mask one bit per
// cycle from task 0 up to the first set bit. The next request is accepted
// once the result is loaded into the output register, even if it has not
// been taken.
module bitmap_priority_task_scheduler import bpts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_data
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  bpts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  bpts_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== design/bpts_chk.sv =====
// Port-level checker for the task scheduler, bound to the top level.
// Depends on bpts_pkg.
`timescale 1ns / 1ps

module bpts_chk import bpts_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input out_rsp_t out_data
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while busy");

  a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.none_ready |-> out_data.ready_now == '0)
    else $error("none_ready with a nonempty ready mask");

  a_none_chosen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.none_ready |-> out_data.chosen_task == '0)
    else $error("none_ready with a chosen task");

  // a nonzero pick comes only from a schedule and becomes the running task
  a_pick_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.chosen_task != '0 |->
      out_data.ready_now[out_data.chosen_task] &&
      out_data.running_task == out_data.chosen_task)
    else $error("chosen task not ready or not running");

endmodule

bind bitmap_priority_task_scheduler bpts_chk u_bpts_chk (.*);

// ===== tb/bpts_tracker_pkg.sv =====
// Scoreboard class for the bitmap priority task scheduler testbench.
// Keeps its own copy of the ready mask, current task and delay timers;
// depends on bpts_pkg for the request and result types.
`timescale 1ns / 1ps

package bpts_tracker_pkg;
  import bpts_pkg::*;

  class sched_tracker;
    logic [DATA_W-1:0] ready_mask_q;
    logic [TASK_W-1:0] cur_task_q;
    logic [DATA_W-1:0] timers [NUM_TASKS];
    out_rsp_t          due_results [$];

    int unsigned requests;
    int unsigned checked;
    int unsigned mismatches;
    int unsigned ticks;
    int unsigned wakeups;
    int unsigned schedules;
    int unsigned empty_schedules;
    int unsigned idle_picks;

    function new();
      ready_mask_q = '0;
      cur_task_q   = '0;
      foreach (timers[i]) timers[i] = '0;
      requests        = 0;
      checked         = 0;
      mismatches      = 0;
      ticks           = 0;
      wakeups         = 0;
      schedules       = 0;
      empty_schedules = 0;
      idle_picks      = 0;
    endfunction

    // Advance the scheduler state by one accepted request and queue its result.
    function void note_request(in_req_t req);
      out_rsp_t rsp;
      logic     found;
      rsp   = '0;
      found = 1'b0;
      requests++;
      case (req.cmd)
        CMD_TICK: begin
          ticks++;
          for (int i = 0; i < NUM_TASKS; i++) begin
            if (timers[i] != '0) begin
              timers[i] = timers[i] - 1'b1;
              if (timers[i] == '0) begin
                ready_mask_q[i] = 1'b1;
                wakeups++;
              end
            end
          end
        end
        CMD_READY: ready_mask_q = ready_mask_q | (req.ready_mask & TASK_MASK);
        CMD_BLOCK, CMD_DELAY: begin
          if (int'(cur_task_q) < NUM_TASKS) begin
            ready_mask_q[cur_task_q] = 1'b0;
            if (req.cmd == CMD_DELAY) timers[cur_task_q] = req.delay_ticks;
          end
        end
        CMD_SCHEDULE: begin
          schedules++;
          if ((ready_mask_q & TASK_MASK) == '0) begin
            rsp.none_ready = 1'b1;
            empty_schedules++;
          end else begin
            for (int i = 0; i < NUM_TASKS; i++) begin
              if (!found && ready_mask_q[i]) begin
                found           = 1'b1;
                rsp.chosen_task = TASK_W'(i);
              end
            end
            cur_task_q = rsp.chosen_task;
            if (int'(rsp.chosen_task) == NUM_TASKS - 1) idle_picks++;
          end
        end
        default: ;  // spare codes leave the state alone
      endcase
      ready_mask_q     = ready_mask_q & TASK_MASK;
      rsp.ready_now    = ready_mask_q;
      rsp.running_task = cur_task_q;
      due_results.push_back(rsp);
    endfunction

    function void check_result(out_rsp_t got);
      out_rsp_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing outstanding: %h", got);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (got.chosen_task !== want.chosen_task) begin
        $error("chosen_task: expected %0d, got %0d", want.chosen_task, got.chosen_task);
        mismatches++;
      end
      if (got.none_ready !== want.none_ready) begin
        $error("none_ready: expected %0b, got %0b", want.none_ready, got.none_ready);
        mismatches++;
      end
      if (got.ready_now !== want.ready_now) begin
        $error("ready_now: expected %h, got %h", want.ready_now, got.ready_now);
        mismatches++;
      end
      if (got.running_task !== want.running_task) begin
        $error("running_task: expected %0d, got %0d", want.running_task, got.running_task);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction
  endclass

endpackage

// ===== tb/bitmap_priority_task_scheduler_test.sv =====
// Top-level testbench for bitmap_priority_task_scheduler: directed and random
// requests, random idling on both channels, results checked by sched_tracker.
// Depends on bpts_pkg and bpts_tracker_pkg.
`timescale 1ns / 1ps

module bitmap_priority_task_scheduler_test;
  import bpts_pkg::*;
  import bpts_tracker_pkg::*;

  localparam int          RANDOM_REQUESTS = 1625;
  localparam int          CALM_REQUESTS   = 150;
  localparam int          QUIET_LIMIT     = 2000;
  localparam int          DRAIN_CYCLES    = 40;
  localparam logic [2:0]  CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  CMD_SPARE_MID   = 3'd6;
  localparam logic [2:0]  CMD_SPARE_LAST  = 3'd7;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_data;

  sched_tracker tracker = new();

  // One chance in idle_rate per request / cycle of starting an idle burst; 0 means none.
  int          idle_rate = 0;
  int          stall_left = 0;
  int unsigned quiet_cycles = 0;

  bitmap_priority_task_scheduler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: check taken results, stall in random bursts.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_data);
    if (idle_rate != 0 && stall_left == 0 && $urandom_range(0, idle_rate - 1) == 0)
      stall_left = $urandom_range(1, 16);
    if (idle_rate == 0) stall_left = 0;
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Give up when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_req_t make_req(logic [2:0] cmd, logic [DATA_W-1:0] mask,
                                       logic [DATA_W-1:0] dly);
    in_req_t req;
    req.cmd         = cmd;
    req.ready_mask  = mask;
    req.delay_ticks = dly;
    return req;
  endfunction

  // Mostly short delays and sparse masks so that timers expire and tasks rotate.
  function automatic in_req_t random_request();
    in_req_t     req;
    int unsigned pick;
    int unsigned sel;
    req  = make_req(CMD_TICK, $urandom(), $urandom());
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 99);
    if (pick < 28) begin
      req.cmd = CMD_TICK;
    end else if (pick < 43) begin
      req.cmd = CMD_READY;
      if (sel < 40)      req.ready_mask = DATA_W'(1) << $urandom_range(0, NUM_TASKS - 1);
      else if (sel < 65) req.ready_mask = $urandom() & $urandom();
      else if (sel < 85) req.ready_mask = $urandom();
      else if (sel < 95) req.ready_mask = '0;
      else               req.ready_mask = '1;
    end else if (pick < 53) begin
      req.cmd = CMD_BLOCK;
    end else if (pick < 71) begin
      req.cmd = CMD_DELAY;
      if (sel < 60)      req.delay_ticks = $urandom_range(1, 6);
      else if (sel < 75) req.delay_ticks = $urandom_range(7, 40);
      else if (sel < 85) req.delay_ticks = '0;
      else               req.delay_ticks = $urandom();
    end else if (pick < 95) begin
      req.cmd = CMD_SCHEDULE;
    end else begin
      req.cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    end
    return req;
  endfunction

  // Drive one request and hold it until the block takes it.
  task automatic issue_request(in_req_t req);
    if (idle_rate != 0 && $urandom_range(0, idle_rate - 1) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(req);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty mask, idle task alone, wakeups, zero and maximum delays,
    // spare command codes, masks at both extremes.
    issue_request(make_req(CMD_SCHEDULE, '0, '0));
    issue_request(make_req(CMD_TICK, '1, '1));
    issue_request(make_req(CMD_BLOCK, '1, '1));
    issue_request(make_req(CMD_READY, 32'h8000_0000, '0));
    issue_request(make_req(CMD_SCHEDULE, '1, '1));
    issue_request(make_req(CMD_DELAY, '0, '1));
    issue_request(make_req(CMD_READY, '1, '0));
    issue_request(make_req(CMD_SCHEDULE, '0, '0));
    issue_request(make_req(CMD_BLOCK, '0, '0));
    issue_request(make_req(CMD_SCHEDULE, '0, '0));
    issue_request(make_req(CMD_DELAY, '0, 32'd1));
    issue_request(make_req(CMD_TICK, '0, '0));
    issue_request(make_req(CMD_SCHEDULE, '0, '0));
    issue_request(make_req(CMD_DELAY, '1, '0));
    issue_request(make_req(CMD_TICK, '0, '0));
    issue_request(make_req(CMD_SCHEDULE, '0, '0));
    issue_request(make_req(CMD_DELAY, '0, 32'd2));
    issue_request(make_req(CMD_READY, '0, '1));
    issue_request(make_req(CMD_SPARE_FIRST, '1, '1));
    issue_request(make_req(CMD_SPARE_MID, '1, 32'd3));
    issue_request(make_req(CMD_SPARE_LAST, 32'h5555_5555, '1));
    issue_request(make_req(CMD_TICK, '0, '0));
    issue_request(make_req(CMD_TICK, '0, '0));
    issue_request(make_req(CMD_SCHEDULE, '0, '0));
    issue_request(make_req(CMD_READY, 32'h0000_0002, '0));

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // Change the idling pace every hundred requests; quiet stretches included.
      if (n % 100 == 0) begin
        case ($urandom_range(0, 3))
          0:       idle_rate = 0;
          1:       idle_rate = 3;
          2:       idle_rate = 6;
          default: idle_rate = 12;
        endcase
      end
      if (n >= RANDOM_REQUESTS - CALM_REQUESTS) idle_rate = 0;
      issue_request(random_request());
    end
    in_valid <= 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests, %0d results checked: %0d ticks waking %0d tasks",
             tracker.requests, tracker.checked, tracker.ticks, tracker.wakeups);
    $display("%0d schedules, %0d with nothing ready, %0d picking the idle task",
             tracker.schedules, tracker.empty_schedules, tracker.idle_picks);
    if (tracker.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
